// ----- hdl/svt_pkg.sv -----
// svt_pkg: shared types and constants of the sorted value table
// no dependencies; imported by svt_cell, svt_chain and sorted_value_table
`default_nettype none

package svt_pkg;

    // table geometry
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OUT_W    = 7;

    // request opcodes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic                    cmp_en;
        logic                    ins_en;
        logic                    del_en;
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] value;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/svt_cell.sv -----
// svt_cell: one slot of the sorted table with its compare flags
// depends on svt_pkg
`default_nettype none

module svt_cell
    import svt_pkg::*;
(
    input  wire logic                    clk,
    input  wire cell_cmd_t               cmd,
    input  wire logic [IDX_W-1:0]        idx,
    input  wire logic signed [VAL_W-1:0] left_entry,
    input  wire logic                    left_ge,
    input  wire logic                    left_ins,
    input  wire logic signed [VAL_W-1:0] right_entry,
    output logic signed [VAL_W-1:0]      entry,
    output logic                         ge,
    output logic                         ins,
    output logic                         hit
);

    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] entry_next;
    logic                    ge_reg;
    logic                    eq_reg;
    logic                    valid;
    logic                    at_end;

    // slot holds a live entry when it lies below the count
    assign valid  = CNT_W'(idx) < cmd.count;
    assign at_end = CNT_W'(idx) == cmd.count;

    // slot takes part in an insert shift: from lower bound up to the first free slot
    assign ins = (valid && ge_reg) || at_end;

    // first entry not below the value, and equal to it
    assign hit = ge_reg && !left_ge && eq_reg;

    assign entry = entry_reg;
    assign ge    = ge_reg;

    // shift up on insert, shift down on delete
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins_en && ins)
        begin
            entry_next = left_ins ? left_entry : cmd.value;
        end
        else if (cmd.del_en && ge_reg)
        begin
            entry_next = right_entry;
        end
    end

    // entry storage and compare flags
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (cmd.cmp_en)
        begin
            ge_reg <= valid && (entry_reg >= cmd.value);
            eq_reg <= valid && (entry_reg == cmd.value);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/svt_chain.sv -----
// svt_chain: row of svt_cell slots linked to their neighbors
// depends on svt_pkg and svt_cell
`default_nettype none

module svt_chain
    import svt_pkg::*;
(
    input  wire logic          clk,
    input  wire cell_cmd_t     cmd,
    output logic [CAPACITY-1:0] hit
);

    logic signed [VAL_W-1:0] entry_w [CAPACITY];
    logic                    ge_w    [CAPACITY];
    logic                    ins_w   [CAPACITY];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [VAL_W-1:0] left_entry;
            logic                    left_ge;
            logic                    left_ins;
            logic signed [VAL_W-1:0] right_entry;

            // neighbor links, the ends of the row tied off
            if (i == 0)
            begin : g_head
                assign left_entry = '0;
                assign left_ge    = 1'b0;
                assign left_ins   = 1'b0;
            end
            else
            begin : g_body
                assign left_entry = entry_w[i-1];
                assign left_ge    = ge_w[i-1];
                assign left_ins   = ins_w[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_entry = entry_w[i];
            end
            else
            begin : g_mid
                assign right_entry = entry_w[i+1];
            end

            svt_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .idx         (IDX_W'(i)),
                .left_entry  (left_entry),
                .left_ge     (left_ge),
                .left_ins    (left_ins),
                .right_entry (right_entry),
                .entry       (entry_w[i]),
                .ge          (ge_w[i]),
                .ins         (ins_w[i]),
                .hit         (hit[i])
            );
        end
    endgenerate

endmodule

`default_nettype wire

// ----- hdl/sorted_value_table.sv -----
// sorted_value_table: ascending table of signed values with insert, delete and find
// Each request (start while busy is low) goes through these steps: every cell compares its
// entry with the value at once, a one-hot OR reduction over the cells finds the
// first match, and the cells then shift in one step; busy is high through the compare,
// reduce and update steps, and done pulses for one cycle after them with
// the result, which cannot be held off; the next request can be taken in that cycle.
// depends on svt_pkg and svt_chain
`default_nettype none

module sorted_value_table
    import svt_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [1:0]              opcode,
    input  wire logic signed [VAL_W-1:0] value,
    output logic                         busy,
    output logic                         done,
    output logic [OUT_W-1:0]             position,
    output logic                         success,
    output logic [OUT_W-1:0]             entry_count
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_RED  = 4'b0100,
        ST_UPD  = 4'b1000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    op_t                     op_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    found_reg;
    logic [CNT_W-1:0]        pos_reg;
    logic [CNT_W-1:0]        pos_next;
    logic                    done_reg;
    logic [CNT_W-1:0]        position_reg;
    logic [CNT_W-1:0]        position_next;
    logic                    success_reg;
    logic                    success_next;
    logic [CNT_W-1:0]        result_count_reg;
    logic                    full;
    logic                    accept;
    logic [CAPACITY-1:0]     hit;
    cell_cmd_t               cmd;

    assign busy   = state_reg != ST_IDLE;
    assign accept = start && !busy;
    assign full   = count_reg == CNT_W'(CAPACITY);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CMP;
            ST_CMP:  state_next = ST_RED;
            ST_RED:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // command to the cell row
    always_comb
    begin
        cmd.cmp_en = state_reg == ST_CMP;
        cmd.ins_en = (state_reg == ST_UPD) && (op_reg == OP_INSERT) && !full;
        cmd.del_en = (state_reg == ST_UPD) && (op_reg == OP_DELETE) && found_reg;
        cmd.count  = count_reg;
        cmd.value  = value_reg;
    end

    svt_chain u_chain (
        .clk (clk),
        .cmd (cmd),
        .hit (hit)
    );

    // position of the one matching cell, zero when none
    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (hit[i])
            begin
                pos_next = pos_next | CNT_W'(i + 1);
            end
        end
    end

    // result and new count
    always_comb
    begin
        count_next    = count_reg;
        position_next = '0;
        success_next  = 1'b0;
        case (op_reg)
            OP_INSERT:
            begin
                if (!full)
                begin
                    count_next   = count_reg + CNT_W'(1);
                    success_next = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (found_reg)
                begin
                    count_next   = count_reg - CNT_W'(1);
                    success_next = 1'b1;
                end
            end
            OP_FIND:
            begin
                position_next = pos_reg;
                success_next  = found_reg;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= state_reg == ST_UPD;
            if (state_reg == ST_UPD)
            begin
                count_reg <= count_next;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(opcode);
            value_reg <= value;
        end
        if (state_reg == ST_RED)
        begin
            found_reg <= |hit;
            pos_reg   <= pos_next;
        end
        if (state_reg == ST_UPD)
        begin
            position_reg     <= position_next;
            success_reg      <= success_next;
            result_count_reg <= count_next;
        end
    end

    assign done        = done_reg;
    assign position    = OUT_W'(position_reg);
    assign success     = success_reg;
    assign entry_count = OUT_W'(result_count_reg);

    // count stays within the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // result strobe follows the update step only
    a_done_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_UPD))
        else $error("result strobe without update step");

    // at most one cell matches
    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RED) |-> $onehot0(hit))
        else $error("more than one first match");

    // an accepted insert into a table with room grows the count by one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD && op_reg == OP_INSERT && !full)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the count");

endmodule

`default_nettype wire
